@@ hw/rtl/hlwp_pkg.sv @@
// Shared types, constants and character helpers for the hex line word parser.
// Used by hlwp_core, hlwp_out_fifo and hex_line_word_parser.
`timescale 1ns / 1ps

package hlwp_pkg;

  localparam int unsigned WordBits = 32;
  localparam int unsigned LineBits = 20;
  localparam int unsigned QDepth   = 4;
  localparam int unsigned QAw      = $clog2(QDepth);
  localparam int unsigned QCntW    = $clog2(QDepth + 1);

  localparam logic [7:0] CharHash = 8'h23;
  localparam logic [7:0] CharZero = 8'h30;
  localparam logic [7:0] CharLowX = 8'h78;
  localparam logic [7:0] CharUpX  = 8'h58;
  localparam logic [7:0] CharNl   = 8'h0A;

  typedef enum logic [1:0] {
    KIND_WORD  = 2'd0,
    KIND_ERROR = 2'd1,
    KIND_END   = 2'd2
  } kind_e;

  typedef enum logic {
    CMD_CHAR = 1'b0,
    CMD_END  = 1'b1
  } cmd_e;

  typedef struct packed {
    kind_e                kind;
    logic [WordBits-1:0]  word;
    logic [LineBits-1:0]  line;
    logic                 last;
  } result_t;

  typedef struct packed {
    logic [QCntW-1:0] count;
    logic             room;
  } q_status_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_digit(input logic [7:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.val = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.val = 4'(c - 8'h61 + 8'd10);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.val = 4'(c - 8'h41 + 8'd10);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

  // space, tab, VT, FF, CR
  function automatic logic is_blank(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0B) || (c == 8'h0C) || (c == 8'h0D);
  endfunction

endpackage

@@ hw/rtl/hlwp_out_fifo.sv @@
// Result queue: up to two pushes per cycle, one pop per cycle unless stalled.
// Depends on hlwp_pkg for result_t and queue sizing.
`timescale 1ns / 1ps

module hlwp_out_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [1:0]           push_n_i,
  input  hlwp_pkg::result_t    res0_i,
  input  hlwp_pkg::result_t    res1_i,
  output hlwp_pkg::q_status_t  status_o,
  output logic                 valid_o,
  input  logic                 stall_i,
  output hlwp_pkg::result_t    res_o
);

  hlwp_pkg::result_t                 mem_q [hlwp_pkg::QDepth];
  logic [hlwp_pkg::QAw-1:0]          wr_ptr_q, wr_ptr_d, wr_nxt;
  logic [hlwp_pkg::QAw-1:0]          rd_ptr_q, rd_ptr_d;
  logic [hlwp_pkg::QCntW-1:0]        count_q, count_d;
  logic                              pop;

  assign valid_o = (count_q != '0);
  assign pop     = valid_o & ~stall_i;
  assign res_o   = mem_q[rd_ptr_q];
  assign wr_nxt  = wr_ptr_q + hlwp_pkg::QAw'(1);

  assign status_o.count = count_q;
  assign status_o.room  = (count_q <= hlwp_pkg::QCntW'(hlwp_pkg::QDepth - 2));

  always_comb begin
    wr_ptr_d = wr_ptr_q + hlwp_pkg::QAw'(push_n_i);
    rd_ptr_d = rd_ptr_q + hlwp_pkg::QAw'(pop);
    count_d  = count_q + hlwp_pkg::QCntW'(push_n_i) - hlwp_pkg::QCntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) begin
      mem_q[wr_ptr_q] <= res0_i;
    end
    if (push_n_i == 2'd2) begin
      mem_q[wr_nxt] <= res1_i;
    end
  end

endmodule

@@ hw/rtl/hlwp_core.sv @@
// Input register and per-character line parser; emits up to two results per beat.
// Depends on hlwp_pkg for types, character constants and hex decode.
`timescale 1ns / 1ps

module hlwp_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  output logic                       stall_o,
  input  logic                       command_i,
  input  logic [7:0]                 char_byte_i,
  input  logic                       room_i,
  output logic [1:0]                 push_n_o,
  output hlwp_pkg::result_t          res0_o,
  output hlwp_pkg::result_t          res1_o
);

  localparam int unsigned WB = hlwp_pkg::WordBits;
  localparam int unsigned LB = hlwp_pkg::LineBits;

  // input register
  logic        in_valid_q, in_valid_d;
  logic        cmd_q;
  logic [7:0]  chr_q;
  logic        take, adv;

  // parse state
  logic          in_comment_q, in_comment_d;
  logic [1:0]    clean_q, clean_d;
  logic          first_zero_q, first_zero_d;
  logic          second_x_q, second_x_d;
  logic [WB-1:0] acc_q, acc_d;
  logic          ovf_q, ovf_d;
  logic          bad_q, bad_d;
  logic [LB-1:0] line_q, line_d;
  logic          halted_q, halted_d;

  assign stall_o = in_valid_q & ~room_i;
  assign take    = valid_i & ~stall_o;
  assign adv     = in_valid_q & room_i;
  assign in_valid_d = take | (in_valid_q & ~room_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      cmd_q <= command_i;
      chr_q <= char_byte_i;
    end
  end

  always_comb begin
    hlwp_pkg::hex_t   h;
    logic [LB-1:0]    line_inc;
    logic             line_bad;
    logic             as_digit;

    in_comment_d = in_comment_q;
    clean_d      = clean_q;
    first_zero_d = first_zero_q;
    second_x_d   = second_x_q;
    acc_d        = acc_q;
    ovf_d        = ovf_q;
    bad_d        = bad_q;
    line_d       = line_q;
    halted_d     = halted_q;
    push_n_o     = 2'd0;

    h        = hlwp_pkg::hex_digit(chr_q);
    line_inc = (line_q == '1) ? line_q : line_q + LB'(1);
    line_bad = bad_q | ovf_q | ((clean_q == 2'd2) & second_x_q);
    as_digit = 1'b1;

    res0_o.kind = line_bad ? hlwp_pkg::KIND_ERROR : hlwp_pkg::KIND_WORD;
    res0_o.word = line_bad ? '0 : acc_q;
    res0_o.line = line_inc;
    res0_o.last = 1'b1;
    res1_o.kind = hlwp_pkg::KIND_END;
    res1_o.word = '0;
    res1_o.line = '0;
    res1_o.last = 1'b1;

    if (adv && !halted_q) begin
      if (cmd_q == hlwp_pkg::CMD_END) begin
        if (clean_q != 2'd0 && line_bad) begin
          // error on the flushed line: halt, no end result
          push_n_o = 2'd1;
          halted_d = 1'b1;
          line_d   = line_inc;
        end else begin
          if (clean_q != 2'd0) begin
            push_n_o    = 2'd2;
            res0_o.last = 1'b0;
          end else begin
            push_n_o = 2'd1;
            res0_o   = res1_o;
          end
          line_d = '0;
        end
        in_comment_d = 1'b0;
        clean_d      = 2'd0;
        first_zero_d = 1'b0;
        second_x_d   = 1'b0;
        acc_d        = '0;
        ovf_d        = 1'b0;
        bad_d        = 1'b0;
      end else if (chr_q == hlwp_pkg::CharNl) begin
        line_d = line_inc;
        if (clean_q != 2'd0) begin
          push_n_o = 2'd1;
          halted_d = line_bad;
        end
        in_comment_d = 1'b0;
        clean_d      = 2'd0;
        first_zero_d = 1'b0;
        second_x_d   = 1'b0;
        acc_d        = '0;
        ovf_d        = 1'b0;
        bad_d        = 1'b0;
      end else if (in_comment_q) begin
        // drop comment text
      end else if (chr_q == hlwp_pkg::CharHash) begin
        in_comment_d = 1'b1;
      end else if (hlwp_pkg::is_blank(chr_q)) begin
        // drop whitespace
      end else begin
        if (clean_q == 2'd0) begin
          first_zero_d = (chr_q == hlwp_pkg::CharZero);
        end else if (clean_q == 2'd1 && first_zero_q &&
                     (chr_q == hlwp_pkg::CharLowX || chr_q == hlwp_pkg::CharUpX)) begin
          second_x_d = 1'b1;
          as_digit   = 1'b0;
        end
        if (as_digit) begin
          if (!h.ok) begin
            bad_d = 1'b1;
          end else begin
            if (acc_q[WB-1 -: 4] != 4'd0) begin
              ovf_d = 1'b1;
            end
            acc_d = {acc_q[WB-5:0], h.val};
          end
        end
        if (clean_q != 2'd3) begin
          clean_d = clean_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_comment_q <= 1'b0;
      clean_q      <= 2'd0;
      first_zero_q <= 1'b0;
      second_x_q   <= 1'b0;
      acc_q        <= '0;
      ovf_q        <= 1'b0;
      bad_q        <= 1'b0;
      line_q       <= '0;
      halted_q     <= 1'b0;
    end else begin
      in_comment_q <= in_comment_d;
      clean_q      <= clean_d;
      first_zero_q <= first_zero_d;
      second_x_q   <= second_x_d;
      acc_q        <= acc_d;
      ovf_q        <= ovf_d;
      bad_q        <= bad_d;
      line_q       <= line_d;
      halted_q     <= halted_d;
    end
  end

endmodule

@@ hw/rtl/hex_line_word_parser.sv @@
// Top level of the hex line word parser: input register, parser, result queue.
// Depends on hlwp_pkg, hlwp_core and hlwp_out_fifo.
`timescale 1ns / 1ps

// Accepts one character or end-of-input beat per cycle while not stalled. Each
// beat lands in an input register and is parsed from there once the queue has
// room; results are written into a four-entry queue, whose head drives the output.
// A newline that ends a line with content gives one result, an end mark up to
// two (word then end), delivered as separate output beats. The parser moves
// on whenever the queue has room for two results, so with the output side
// taking beats the input sustains one beat per cycle; a stalled output fills
// the queue and then stalls the input. After an error result the block
// swallows every beat until reset.

module hex_line_word_parser (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  output logic                            stall_o,
  input  logic                            command_i,
  input  logic [7:0]                      char_byte_i,
  output logic                            valid_o,
  input  logic                            stall_i,
  output logic [1:0]                      kind_o,
  output logic [hlwp_pkg::WordBits-1:0]   word_o,
  output logic [hlwp_pkg::LineBits-1:0]   line_number_o,
  output logic                            last_o
);

  logic                 [1:0] push_n;
  hlwp_pkg::result_t    res0, res1, res_out;
  hlwp_pkg::q_status_t  q_status;

  hlwp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (valid_i),
    .stall_o     (stall_o),
    .command_i   (command_i),
    .char_byte_i (char_byte_i),
    .room_i      (q_status.room),
    .push_n_o    (push_n),
    .res0_o      (res0),
    .res1_o      (res1)
  );

  hlwp_out_fifo u_out_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_n_i (push_n),
    .res0_i   (res0),
    .res1_i   (res1),
    .status_o (q_status),
    .valid_o  (valid_o),
    .stall_i  (stall_i),
    .res_o    (res_out)
  );

  assign kind_o        = res_out.kind;
  assign word_o        = res_out.word;
  assign line_number_o = res_out.line;
  assign last_o        = res_out.last;

  // a push is only allowed with room for two entries
  a_no_overfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_n != 2'd0) |-> q_status.room)
    else $error("result pushed without queue room");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_status.count <= hlwp_pkg::QCntW'(hlwp_pkg::QDepth))
    else $error("result queue count out of range");

  // only the word ahead of an end result may be non-final
  a_nonlast_is_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !last_o) |-> (kind_o == hlwp_pkg::KIND_WORD))
    else $error("non-final result is not a word");

  a_end_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && kind_o == hlwp_pkg::KIND_END) |->
      (word_o == '0 && line_number_o == '0 && last_o))
    else $error("end result carries payload");

endmodule

@@ sim/hlwp_result_checker.sv @@
`timescale 1ns / 1ps
// Result checker for hex_line_word_parser: tracks accepted character beats,
// predicts the words, errors and end marks they cause, and compares output beats.
// Depends on hlwp_pkg for the kind and command codes, the result layout and the widths.

module hlwp_result_checker
  import hlwp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  logic                cmd_i,
  input  logic [7:0]          char_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  logic [1:0]          kind_i,
  input  logic [WordBits-1:0] word_i,
  input  logic [LineBits-1:0] line_i,
  input  logic                last_i,
  output int unsigned         fail_count_o,
  output int unsigned         due_count_o
);

  result_t             due_results[$];
  result_t             want;
  int unsigned         fail_count = 0;

  logic                skip_rest;
  logic [1:0]          kept_cnt;
  logic                lead_zero;
  logic                saw_x;
  logic [WordBits-1:0] acc;
  logic                too_wide;
  logic                bad_char;
  logic [LineBits-1:0] lines_done;
  logic                frozen;

  assign fail_count_o = fail_count;

  task automatic clear_line();
    skip_rest = 1'b0;
    kept_cnt  = '0;
    lead_zero = 1'b0;
    saw_x     = 1'b0;
    acc       = '0;
    too_wide  = 1'b0;
    bad_char  = 1'b0;
  endtask

  task automatic clear_all();
    clear_line();
    lines_done = '0;
    frozen     = 1'b0;
  endtask

  // Shift one hex digit into the word; anything else spoils the line.
  task automatic shift_digit(input logic [7:0] ch);
    logic       is_hex;
    logic [3:0] nib;
    is_hex = 1'b1;
    nib    = ch[3:0];
    if ((ch >= "a" && ch <= "f") || (ch >= "A" && ch <= "F")) begin
      nib = ch[3:0] + 4'd9;
    end else if (!(ch >= "0" && ch <= "9")) begin
      is_hex = 1'b0;
    end
    if (!is_hex) begin
      bad_char = 1'b1;
    end else begin
      if (acc[WordBits-1 -: 4] != '0) too_wide = 1'b1;
      acc = {acc[WordBits-5:0], nib};
    end
  endtask

  task automatic keep_char(input logic [7:0] ch);
    if (kept_cnt == 2'd0) begin
      lead_zero = (ch == CharZero);
      shift_digit(ch);
    end else if (kept_cnt == 2'd1 && lead_zero && (ch == CharLowX || ch == CharUpX)) begin
      saw_x = 1'b1;
    end else begin
      shift_digit(ch);
    end
    if (kept_cnt != 2'd3) kept_cnt = kept_cnt + 2'd1;
  endtask

  task automatic close_line(output logic err);
    result_t r;
    err = 1'b0;
    if (lines_done != '1) lines_done = lines_done + 1'b1;
    if (kept_cnt != 2'd0) begin
      err    = bad_char || too_wide || (kept_cnt == 2'd2 && saw_x);
      r.kind = err ? KIND_ERROR : KIND_WORD;
      r.word = err ? '0 : acc;
      r.line = lines_done;
      r.last = 1'b1;
      due_results = {due_results, r};
      if (err) frozen = 1'b1;
    end
    clear_line();
  endtask

  task automatic parse_beat(input logic cmd, input logic [7:0] ch);
    result_t r;
    logic    err;
    err = 1'b0;
    if (!frozen) begin
      if (cmd == CMD_END) begin
        if (kept_cnt != 2'd0) begin
          close_line(err);
          // the flushed word is no longer the final result of this beat
          if (!err) begin
            r = due_results.pop_back();
            r.last = 1'b0;
            due_results = {due_results, r};
          end
        end
        if (!err) begin
          r.kind = KIND_END;
          r.word = '0;
          r.line = '0;
          r.last = 1'b1;
          due_results = {due_results, r};
          clear_all();
        end
      end else if (ch == CharNl) begin
        close_line(err);
      end else if (skip_rest) begin
      end else if (ch == CharHash) begin
        skip_rest = 1'b1;
      end else if (ch == 8'h20 || (ch >= 8'h09 && ch <= 8'h0D)) begin
        // drop whitespace (newline was handled above)
      end else begin
        keep_char(ch);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_all();
      due_results.delete();
      due_count_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (due_results.size() == 0) begin
          $error("result with none due: kind %0d word %h line %0d last %0d",
                 kind_i, word_i, line_i, last_i);
          fail_count++;
        end else begin
          want = due_results.pop_front();
          if (kind_i != want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, kind_i);
            fail_count++;
          end
          if (word_i != want.word) begin
            $error("word: expected %h, got %h", want.word, word_i);
            fail_count++;
          end
          if (line_i != want.line) begin
            $error("line_number: expected %0d, got %0d", want.line, line_i);
            fail_count++;
          end
          if (last_i != want.last) begin
            $error("last: expected %0d, got %0d", want.last, last_i);
            fail_count++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) parse_beat(cmd_i, char_i);
      due_count_o <= due_results.size();
    end
  end

endmodule

@@ sim/tb_hex_line_word_parser.sv @@
`timescale 1ns / 1ps
// Testbench top for hex_line_word_parser: clock, reset, program text stimulus and verdict.
// Depends on hlwp_pkg, the parser RTL and hlwp_result_checker.

module tb_hex_line_word_parser;
  import hlwp_pkg::*;

  localparam int unsigned TargetBeats = 1450;
  localparam int unsigned CycleLimit  = 100000;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_valid   = 1'b0;
  logic        in_stall;
  logic        cmd        = CMD_CHAR;
  logic [7:0]  char_byte  = 8'h00;
  logic        out_valid;
  logic        out_stall  = 1'b0;
  logic [1:0]  kind;
  logic [31:0] word;
  logic [19:0] line_number;
  logic        last;

  int unsigned fail_count;
  int unsigned due_count;
  int unsigned beats_sent = 0;
  int unsigned cycles     = 0;

  always #4 clk = ~clk;

  hex_line_word_parser uut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .valid_i       (in_valid),
    .stall_o       (in_stall),
    .command_i     (cmd),
    .char_byte_i   (char_byte),
    .valid_o       (out_valid),
    .stall_i       (out_stall),
    .kind_o        (kind),
    .word_o        (word),
    .line_number_o (line_number),
    .last_o        (last)
  );

  hlwp_result_checker u_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .cmd_i        (cmd),
    .char_i       (char_byte),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .kind_i       (kind),
    .word_i       (word),
    .line_i       (line_number),
    .last_i       (last),
    .fail_count_o (fail_count),
    .due_count_o  (due_count)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("** hex_line_word_parser: FAILED **");
      $finish;
    end
  end

  // Output side: random stalls, one long hold-off to back up the input, one quiet stretch.
  initial begin
    int unsigned n;
    n = 0;
    forever begin
      @(posedge clk);
      n++;
      if (n >= 300 && n < 380) begin
        out_stall <= 1'b1;
      end else if (n >= 1200 && n < 1600) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < 31);
      end
    end
  end

  // Offer one beat and hold it until accepted; valid stays high into the next beat.
  task automatic put_beat(input cmd_e c, input logic [7:0] ch);
    if (!(beats_sent >= 700 && beats_sent < 1000) && $urandom_range(99) < 31) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(2, 1)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    cmd       <= c;
    char_byte <= ch;
    do @(posedge clk); while (in_stall);
    beats_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) put_beat(CMD_CHAR, s[i]);
  endtask

  task automatic send_blanks();
    logic [7:0] b;
    while ($urandom_range(99) < 12) begin
      case ($urandom_range(4))
        0:       b = 8'h20;
        1:       b = 8'h09;
        2:       b = 8'h0B;
        3:       b = 8'h0C;
        default: b = 8'h0D;
      endcase
      put_beat(CMD_CHAR, b);
    end
  endtask

  // One well-formed line: optional prefix, leading zeros, up to eight digits,
  // whitespace anywhere, an optional comment of arbitrary bytes.
  task automatic send_random_line();
    int unsigned shape;
    int unsigned ndig;
    logic [3:0]  v;
    logic [7:0]  b;
    shape = $urandom_range(99);
    send_blanks();
    if (shape >= 12) begin
      if ($urandom_range(1)) begin
        put_beat(CMD_CHAR, CharZero);
        send_blanks();
        put_beat(CMD_CHAR, $urandom_range(1) ? CharLowX : CharUpX);
        send_blanks();
      end
      if ($urandom_range(5) == 0) begin
        repeat ($urandom_range(4, 1)) begin
          put_beat(CMD_CHAR, CharZero);
          send_blanks();
        end
      end
      ndig = ($urandom_range(2) == 0) ? 8 : $urandom_range(8, 1);
      repeat (ndig) begin
        v = 4'($urandom_range(15));
        if (v < 10) b = "0" + 8'(v);
        else if ($urandom_range(1)) b = "a" + 8'(v) - 8'd10;
        else b = "A" + 8'(v) - 8'd10;
        put_beat(CMD_CHAR, b);
        send_blanks();
      end
    end
    if (shape >= 6 && shape < 12 || $urandom_range(4) == 0) begin
      put_beat(CMD_CHAR, CharHash);
      repeat ($urandom_range(6)) begin
        b = 8'($urandom_range(255));
        if (b == CharNl) b = 8'hFA;
        put_beat(CMD_CHAR, b);
      end
    end
    if ($urandom_range(99) < 3) begin
      put_beat(CMD_END, 8'($urandom_range(255)));
    end else begin
      put_beat(CMD_CHAR, CharNl);
      if ($urandom_range(99) < 2) put_beat(CMD_END, 8'($urandom_range(255)));
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    send_text("0XfFfFfFfF\n");    // widest word, upper-case prefix, mixed-case digits
    send_text("\n");              // empty line is skipped but counted
    send_text(" 0\r#z\n");        // blanks, a zero word, trailing comment
    put_beat(CMD_CHAR, 8'h0B);
    put_beat(CMD_CHAR, 8'h0C);
    send_text("7");
    put_beat(CMD_END, 8'h00);     // flush an unterminated line, then end
    put_beat(CMD_END, 8'hFF);     // end with nothing pending

    while (beats_sent < TargetBeats) send_random_line();

    // One bad line last: the block halts for good after it.
    case ($urandom_range(3))
      0: begin
        send_text("12");
        put_beat(CMD_CHAR, 8'($urandom_range(8'h77, 8'h67)));
      end
      1:       send_text("0 X");
      2:       send_text("12x4");
      default: send_text("fedcba987");
    endcase
    if ($urandom_range(1)) put_beat(CMD_CHAR, CharNl);
    else put_beat(CMD_END, 8'h00);
    // swallowed while halted
    send_text("5\n");
    put_beat(CMD_END, 8'hFF);
    in_valid <= 1'b0;

    @(posedge clk);
    while (due_count != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && due_count == 0) begin
      $display("** hex_line_word_parser: PASSED **");
    end else begin
      $display("** hex_line_word_parser: FAILED **");
    end
    $finish;
  end

endmodule
